[rtl/spectral_flux_peak_hold_unit_defines.svh]
// Assertion macros used by the spectral flux peak-hold RTL.
// Included by the top module, which carries the concurrent checks; needs nothing else.
`ifndef SPECTRAL_FLUX_PEAK_HOLD_UNIT_DEFINES_SVH
`define SPECTRAL_FLUX_PEAK_HOLD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFPH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfph: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFPH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfph: next-cycle check failed");

`endif

[rtl/sfph_pkg.sv]
// Types and constants of the spectral flux peak-hold unit.
// Used by every module of the block but sfph_ram; depends on nothing.
`timescale 1ns / 1ps

package sfph_pkg;

    localparam int MAG_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int FLUX_W  = 12;

    // 255.0 in unsigned Q8.4.
    localparam logic [FLUX_W-1:0]  FLUX_MAX    = 12'd4080;
    localparam int                 FLUX_MAX_I  = 4080;
    localparam logic [LEVEL_W-1:0] DECAY_RESET = 8'd10;
    localparam logic [7:0]         FLUX_GAIN   = 8'd255;

    // Per-bin result travelling from the update stage to the output stage.
    typedef struct packed {
        logic [LEVEL_W-1:0] held_level;
        logic [FLUX_W-1:0]  flux;
        logic               frame_end;
    } bin_result_t;

endpackage

[rtl/sfph_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the per-bin state of the peak-hold unit; no package dependencies.
`timescale 1ns / 1ps

module sfph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sfph_flux_update.sv]
// Per-bin arithmetic: rectified flux of one bin and its new peak-hold level.
// Depends on sfph_pkg for field widths and the flux limit.
`timescale 1ns / 1ps

module sfph_flux_update (
    input  logic signed [sfph_pkg::MAG_W-1:0]   magnitude,
    input  logic        [sfph_pkg::MAG_W-1:0]   prev_magnitude,
    input  logic        [sfph_pkg::LEVEL_W-1:0] prev_level,
    input  logic        [sfph_pkg::LEVEL_W-1:0] decay_step,
    output logic        [sfph_pkg::FLUX_W-1:0]  flux,
    output logic        [sfph_pkg::LEVEL_W-1:0] held_level
);

    logic signed [sfph_pkg::MAG_W:0]     diff;
    logic        [sfph_pkg::MAG_W+7:0]   scaled;
    logic        [sfph_pkg::MAG_W-1:0]   shifted;
    logic        [sfph_pkg::LEVEL_W-1:0] dropped;
    logic        [sfph_pkg::LEVEL_W-1:0] floor_level;

    always_comb begin
        diff    = {magnitude[sfph_pkg::MAG_W-1], magnitude}
                - {prev_magnitude[sfph_pkg::MAG_W-1], prev_magnitude};
        scaled  = (sfph_pkg::MAG_W+8)'(diff[sfph_pkg::MAG_W-1:0])
                * (sfph_pkg::MAG_W+8)'(sfph_pkg::FLUX_GAIN);
        shifted = scaled[sfph_pkg::MAG_W+7:8];

        // Only a rise counts; a positive difference always fits in MAG_W bits.
        if (diff[sfph_pkg::MAG_W] || (diff == '0)) begin
            flux = '0;
        end else if (shifted > sfph_pkg::MAG_W'(sfph_pkg::FLUX_MAX)) begin
            flux = sfph_pkg::FLUX_MAX;
        end else begin
            flux = shifted[sfph_pkg::FLUX_W-1:0];
        end

        dropped     = (prev_level > decay_step) ? (prev_level - decay_step) : '0;
        floor_level = flux[sfph_pkg::FLUX_W-1:4];
        held_level  = (dropped > floor_level) ? dropped : floor_level;
    end

endmodule

[rtl/sfph_bass_div.sv]
// Output stage: divides the frame's bass flux sum by the bass bin count and
// holds the result register towards the receiver. Depends on sfph_pkg.
`timescale 1ns / 1ps

module sfph_bass_div #(
    parameter int BASS_BINS = 32,
    parameter int SUM_W     = 17
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sfph_pkg::bin_result_t             in_result,
    input  logic [SUM_W-1:0]                  in_sum,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sfph_pkg::LEVEL_W-1:0]      m_held_level,
    output logic [sfph_pkg::FLUX_W-1:0]       m_flux,
    output logic [sfph_pkg::FLUX_W-1:0]       m_bass_average,
    output logic                              m_frame_end
);

    // Exact division by a constant: floor(x * ceil(2^S / B) / 2^S) with
    // S = SUM_W + ceil(log2 B) is exact for every x below 2^SUM_W.
    localparam int DIV_L  = $clog2(BASS_BINS);
    localparam int DIV_S  = SUM_W + DIV_L;
    localparam int MUL_W  = SUM_W + 2;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((64'd1 << DIV_S) + 64'(BASS_BINS) - 64'd1) / 64'(BASS_BINS));

    logic                  p2_valid_reg;
    sfph_pkg::bin_result_t p2_result_reg;
    logic [SUM_W-1:0]      p2_sum_reg;
    logic                  p2_adv;

    logic [PROD_W-1:0]     product;

    logic                              m_valid_reg;
    logic [sfph_pkg::LEVEL_W-1:0]      m_held_level_reg;
    logic [sfph_pkg::FLUX_W-1:0]       m_flux_reg;
    logic [sfph_pkg::FLUX_W-1:0]       m_bass_average_reg;
    logic                              m_frame_end_reg;

    assign p2_adv   = !m_valid_reg || m_ready;
    assign in_ready = !p2_valid_reg || p2_adv;
    assign product  = PROD_W'(p2_sum_reg) * PROD_W'(DIV_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                p2_valid_reg <= in_valid;
            end
            if (p2_adv) begin
                m_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            p2_result_reg <= in_result;
            p2_sum_reg    <= in_sum;
        end
        if (p2_valid_reg && p2_adv) begin
            m_held_level_reg   <= p2_result_reg.held_level;
            m_flux_reg         <= p2_result_reg.flux;
            m_frame_end_reg    <= p2_result_reg.frame_end;
            m_bass_average_reg <= product[DIV_S +: sfph_pkg::FLUX_W];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_held_level   = m_held_level_reg;
    assign m_flux         = m_flux_reg;
    assign m_bass_average = m_bass_average_reg;
    assign m_frame_end    = m_frame_end_reg;

endmodule

[rtl/spectral_flux_peak_hold_unit.sv]
// Spectral flux meter with per-bin peak hold.
//
// Input requests carry one log-magnitude bin (s_magnitude, signed Q4.12) and a
// last-bin flag; bins arrive in order from bin 0. Each accepted request gives
// exactly one result request on the m_ channel: the bin's updated held level,
// its rectified flux in Q8.4, and on the frame's last bin the bass average.
// Both channels use valid/ready. cfg_wr_en writes decay_step; the user must
// use cfg_wr_en only while the block is idle; the block does not enforce it.
//
// From input acceptance to m_valid a request passes the update stage, the
// division stage and the output register: the state memories are read at the
// accepting edge, the flux update and write-back use that data in the update
// stage, and the bass division fills the output register from the division
// stage. Throughput is one bin per cycle while m_ready is held high, set by
// the single read and write port of each state memory. A repeated bin 0 (a
// frame of one bin) is served from forwarding registers.
// Reset clears control state and sets decay_step to 10. The state memories
// are not swept: a fill count marks which bins have been written, and bins
// beyond it read as zero. When the receiver stalls, the pipeline keeps
// accepting requests until its three stages are full, then holds s_ready low.
`timescale 1ns / 1ps
`include "spectral_flux_peak_hold_unit_defines.svh"

module spectral_flux_peak_hold_unit #(
    parameter int BINS      = 512,
    parameter int BASS_BINS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [7:0]                        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sfph_pkg::MAG_W-1:0] s_magnitude,
    input  logic                              s_last_bin,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sfph_pkg::LEVEL_W-1:0]      m_held_level,
    output logic [sfph_pkg::FLUX_W-1:0]       m_flux,
    output logic [sfph_pkg::FLUX_W-1:0]       m_bass_average,
    output logic                              m_frame_end
);

    localparam int IDX_W  = $clog2(BINS);
    localparam int FILL_W = $clog2(BINS + 1);
    localparam int SUM_W  = $clog2(BASS_BINS * sfph_pkg::FLUX_MAX_I + 1);

    // Control and configuration.
    logic [sfph_pkg::LEVEL_W-1:0] decay_step_reg;
    logic [IDX_W-1:0]             bin_counter_reg;
    logic [IDX_W-1:0]             bin_counter_next;
    logic [FILL_W-1:0]            fill_reg;
    logic [SUM_W-1:0]             bass_sum_reg;
    logic [SUM_W-1:0]             bass_sum_next;
    logic                         s_accept;

    // Update stage, aligned with the memory read data.
    logic                              p1_valid_reg;
    logic signed [sfph_pkg::MAG_W-1:0] p1_mag_reg;
    logic                              p1_last_reg;
    logic [IDX_W-1:0]                  p1_idx_reg;
    logic                              p1_bass_reg;
    logic                              p1_wrap_reg;
    logic                              p1_fwd_reg;
    logic                              p1_rd_valid_reg;
    logic                              p1_adv;
    logic                              fwd_hit;

    logic [sfph_pkg::MAG_W-1:0]   fwd_mag_reg;
    logic [sfph_pkg::LEVEL_W-1:0] fwd_level_reg;

    logic [sfph_pkg::MAG_W-1:0]   mag_rd_data;
    logic [sfph_pkg::LEVEL_W-1:0] level_rd_data;
    logic [sfph_pkg::MAG_W-1:0]   prev_mag;
    logic [sfph_pkg::LEVEL_W-1:0] prev_level;
    logic [sfph_pkg::FLUX_W-1:0]  flux;
    logic [sfph_pkg::LEVEL_W-1:0] new_level;
    logic [SUM_W-1:0]             sum_total;

    sfph_pkg::bin_result_t        upd_result;
    logic [SUM_W-1:0]             upd_sum;
    logic                         div_ready;

    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;
    assign p1_adv   = p1_valid_reg && div_ready;

    // The entry written back this cycle is the one being read now only for a
    // frame of a single bin; its new values are then taken from registers.
    assign fwd_hit = p1_adv && (p1_idx_reg == bin_counter_reg);

    always_comb begin
        if (s_last_bin || (bin_counter_reg == IDX_W'(BINS - 1))) begin
            bin_counter_next = '0;
        end else begin
            bin_counter_next = bin_counter_reg + 1'b1;
        end
    end

    sfph_ram #(
        .WIDTH (sfph_pkg::MAG_W),
        .DEPTH (BINS)
    ) u_mag_ram (
        .aclk    (aclk),
        .wr_en   (p1_adv),
        .wr_addr (p1_idx_reg),
        .wr_data (p1_mag_reg),
        .rd_en   (s_accept),
        .rd_addr (bin_counter_reg),
        .rd_data (mag_rd_data)
    );

    sfph_ram #(
        .WIDTH (sfph_pkg::LEVEL_W),
        .DEPTH (BINS)
    ) u_level_ram (
        .aclk    (aclk),
        .wr_en   (p1_adv),
        .wr_addr (p1_idx_reg),
        .wr_data (new_level),
        .rd_en   (s_accept),
        .rd_addr (bin_counter_reg),
        .rd_data (level_rd_data)
    );

    always_comb begin
        if (p1_fwd_reg) begin
            prev_mag   = fwd_mag_reg;
            prev_level = fwd_level_reg;
        end else if (p1_rd_valid_reg) begin
            prev_mag   = mag_rd_data;
            prev_level = level_rd_data;
        end else begin
            prev_mag   = '0;
            prev_level = '0;
        end
    end

    sfph_flux_update u_update (
        .magnitude      (p1_mag_reg),
        .prev_magnitude (prev_mag),
        .prev_level     (prev_level),
        .decay_step     (decay_step_reg),
        .flux           (flux),
        .held_level     (new_level)
    );

    always_comb begin
        sum_total = bass_sum_reg + (p1_bass_reg ? SUM_W'(flux) : '0);
        if (p1_last_reg || p1_wrap_reg) begin
            bass_sum_next = '0;
        end else begin
            bass_sum_next = sum_total;
        end
        upd_result.held_level = new_level;
        upd_result.flux       = flux;
        upd_result.frame_end  = p1_last_reg;
        // Only a closing bin carries a sum; zero divides to a zero average.
        upd_sum = p1_last_reg ? sum_total : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_step_reg  <= sfph_pkg::DECAY_RESET;
            bin_counter_reg <= '0;
            fill_reg        <= '0;
            bass_sum_reg    <= '0;
            p1_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                decay_step_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                bin_counter_reg <= bin_counter_next;
            end
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (p1_adv) begin
                bass_sum_reg <= bass_sum_next;
                if (FILL_W'(p1_idx_reg) >= fill_reg) begin
                    fill_reg <= FILL_W'(p1_idx_reg) + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_mag_reg      <= s_magnitude;
            p1_last_reg     <= s_last_bin;
            p1_idx_reg      <= bin_counter_reg;
            p1_bass_reg     <= (32'(bin_counter_reg) < BASS_BINS);
            p1_wrap_reg     <= (bin_counter_reg == IDX_W'(BINS - 1));
            p1_fwd_reg      <= fwd_hit;
            p1_rd_valid_reg <= (FILL_W'(bin_counter_reg) < fill_reg);
        end
        if (p1_adv) begin
            fwd_mag_reg   <= p1_mag_reg;
            fwd_level_reg <= new_level;
        end
    end

    sfph_bass_div #(
        .BASS_BINS (BASS_BINS),
        .SUM_W     (SUM_W)
    ) u_bass_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (p1_valid_reg),
        .in_ready       (div_ready),
        .in_result      (upd_result),
        .in_sum         (upd_sum),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_held_level   (m_held_level),
        .m_flux         (m_flux),
        .m_bass_average (m_bass_average),
        .m_frame_end    (m_frame_end)
    );

    `SFPH_ASSERT_IMP(a_fwd_only_bin0, aclk, aresetn, p1_valid_reg && p1_fwd_reg, p1_idx_reg == '0)
    `SFPH_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(BINS))
    `SFPH_ASSERT_NEXT(a_frame_restart, aclk, aresetn, s_accept && s_last_bin, bin_counter_reg == '0)
    `SFPH_ASSERT_NEXT(a_update_hold, aclk, aresetn, p1_valid_reg && !p1_adv, p1_valid_reg && $stable(p1_idx_reg))
    `SFPH_ASSERT_IMP(a_bass_on_end, aclk, aresetn, m_valid && !m_frame_end, m_bass_average == '0)

endmodule

[tb/spectral_flux_peak_hold_unit_tb.sv]
// Self-checking testbench for spectral_flux_peak_hold_unit: a directed table, then random frames,
// each result matched to a hand-worked value or a local model of the flux and peak-hold arithmetic.
// Depends on sfph_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module spectral_flux_peak_hold_unit_tb;

    localparam int METER_BINS     = 512;
    localparam int BASS_SPAN      = 32;
    localparam int RESET_CYCLES   = 10;
    localparam int TAIL_CYCLES    = 8;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int MAX_PRINTS     = 100;
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES    = 90;

    typedef struct packed {
        logic [sfph_pkg::LEVEL_W-1:0] held_level;
        logic [sfph_pkg::FLUX_W-1:0]  flux;
        logic [sfph_pkg::FLUX_W-1:0]  bass_average;
        logic                         frame_end;
    } meter_out_t;

    typedef struct packed {
        logic [sfph_pkg::MAG_W-1:0] magnitude;
        logic                       last_bin;
        logic                       typed;
        meter_out_t                 want;
    } stim_row_t;

    typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_mode_e;

    // Rows marked typed carry a hand-worked result; the others are checked against the model.
    // Decay is at its reset value of 10 throughout the table.
    localparam int DIR_ROWS = 22;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{16'h7FFF, 1'b0, 1'b1, '{8'd255, 12'd4080, 12'd0, 1'b0}},
        '{16'h8000, 1'b0, 1'b1, '{8'd0, 12'd0, 12'd0, 1'b0}},
        '{16'h0001, 1'b0, 1'b1, '{8'd0, 12'd0, 12'd0, 1'b0}},
        '{16'h1000, 1'b1, 1'b1, '{8'd255, 12'd4080, 12'd255, 1'b1}},
        '{16'h8000, 1'b0, 1'b1, '{8'd245, 12'd0, 12'd0, 1'b0}},
        '{16'h7FFF, 1'b0, 1'b1, '{8'd255, 12'd4080, 12'd0, 1'b0}},
        '{16'h0011, 1'b0, 1'b0, '0},
        '{16'h1000, 1'b0, 1'b0, '0},
        '{16'h0064, 1'b0, 1'b0, '0},
        '{16'hFFFF, 1'b1, 1'b0, '0},
        '{16'h8100, 1'b1, 1'b0, '0},
        '{16'h8400, 1'b1, 1'b0, '0},
        '{16'h7FFF, 1'b1, 1'b1, '{8'd255, 12'd4080, 12'd127, 1'b1}},
        '{16'h7FFF, 1'b1, 1'b1, '{8'd245, 12'd0, 12'd0, 1'b1}},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0200, 1'b1, 1'b0, '0},
        '{16'h0100, 1'b0, 1'b0, '0},
        '{16'h0200, 1'b1, 1'b0, '0},
        '{16'h1010, 1'b0, 1'b0, '0},
        '{16'h0F00, 1'b0, 1'b0, '0},
        '{16'hE000, 1'b0, 1'b0, '0},
        '{16'h2000, 1'b1, 1'b0, '0}
    };

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [7:0]                        cfg_wr_data = 8'd0;
    logic                              s_valid     = 1'b0;
    logic                              s_ready;
    logic signed [sfph_pkg::MAG_W-1:0] s_magnitude = '0;
    logic                              s_last_bin  = 1'b0;
    logic                              m_valid;
    logic                              m_ready     = 1'b0;
    logic [sfph_pkg::LEVEL_W-1:0]      m_held_level;
    logic [sfph_pkg::FLUX_W-1:0]       m_flux;
    logic [sfph_pkg::FLUX_W-1:0]       m_bass_average;
    logic                              m_frame_end;

    // Model state and its copy of the decay register.
    logic [sfph_pkg::MAG_W-1:0]   prev_mag [METER_BINS];
    logic [sfph_pkg::LEVEL_W-1:0] held_lvl [METER_BINS];
    int                           bin_idx       = 0;
    int                           bass_acc      = 0;
    int                           decay_setting = int'(sfph_pkg::DECAY_RESET);

    meter_out_t  expected_bins [$];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    int          mode_left      = 0;
    ready_mode_e ready_mode     = READY_ALWAYS;

    spectral_flux_peak_hold_unit #(
        .BINS      (METER_BINS),
        .BASS_BINS (BASS_SPAN)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_magnitude    (s_magnitude),
        .s_last_bin     (s_last_bin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_held_level   (m_held_level),
        .m_flux         (m_flux),
        .m_bass_average (m_bass_average),
        .m_frame_end    (m_frame_end)
    );

    always #10 aclk = ~aclk;

    function automatic meter_out_t step_meter(input logic [sfph_pkg::MAG_W-1:0] mag,
                                              input logic last);
        meter_out_t r;
        int rise;
        int flux_q;
        int lvl;
        int dropped;
        rise = int'($signed(mag)) - int'($signed(prev_mag[bin_idx]));
        flux_q = 0;
        if (rise > 0) begin
            flux_q = (rise * int'(sfph_pkg::FLUX_GAIN)) >> 8;
        end
        if (flux_q > sfph_pkg::FLUX_MAX_I) begin
            flux_q = sfph_pkg::FLUX_MAX_I;
        end
        lvl = int'(held_lvl[bin_idx]);
        dropped = (lvl > decay_setting) ? lvl - decay_setting : 0;
        lvl = (dropped > (flux_q >> 4)) ? dropped : (flux_q >> 4);
        held_lvl[bin_idx] = sfph_pkg::LEVEL_W'(lvl);
        prev_mag[bin_idx] = mag;
        if (bin_idx < BASS_SPAN) begin
            bass_acc += flux_q;
        end
        r.held_level   = sfph_pkg::LEVEL_W'(lvl);
        r.flux         = sfph_pkg::FLUX_W'(flux_q);
        r.frame_end    = last;
        r.bass_average = '0;
        if (last) begin
            r.bass_average = sfph_pkg::FLUX_W'(bass_acc / BASS_SPAN);
            bass_acc = 0;
            bin_idx  = 0;
        end else if (bin_idx + 1 >= METER_BINS) begin
            // A frame that runs past the last bin starts over without a frame end.
            bass_acc = 0;
            bin_idx  = 0;
        end else begin
            bin_idx++;
        end
        return r;
    endfunction

    // Mostly modest rises over the bin's previous value, so that the flux lands across its
    // whole range and around the clamp, with full-range values and extremes mixed in.
    function automatic logic [sfph_pkg::MAG_W-1:0] pick_magnitude();
        logic [sfph_pkg::MAG_W-1:0] base;
        int roll;
        base = prev_mag[bin_idx];
        roll = $urandom_range(0, 99);
        if (roll < 55) return base + 16'($urandom_range(0, 4400)) - 16'd300;
        if (roll < 75) return 16'($urandom());
        if (roll < 82) return 16'h7FFF;
        if (roll < 89) return 16'h8000;
        return base;
    endfunction

    function automatic int pick_frame_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 1;
        if (roll < 45) return $urandom_range(2, 12);
        if (roll < 75) return $urandom_range(28, 36);
        return $urandom_range(13, 90);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, what,
                     got, want);
        end
    endtask

    // Called at a rising edge; returns at the edge where the request is accepted.
    task automatic send_bin(input logic [sfph_pkg::MAG_W-1:0] mag, input logic last,
                            input logic typed, input meter_out_t typed_want);
        meter_out_t model_out;
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_magnitude <= mag;
        s_last_bin  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model_out = step_meter(mag, last);
        expected_bins = {expected_bins, (typed ? typed_want : model_out)};
    endtask

    task automatic run_frames(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = pick_frame_len();
            if (len > budget - sent) begin
                len = budget - sent;
            end
            for (int i = 0; i < len; i++) begin
                send_bin(pick_magnitude(), i == len - 1, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    // The register is only touched once the pipeline has drained.
    task automatic write_decay(input logic [7:0] value);
        s_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        decay_setting = int'(value);
    endtask

    initial begin : stimulus
        for (int i = 0; i < METER_BINS; i++) begin
            prev_mag[i] = '0;
            held_lvl[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_bin(DIRECTED[r].magnitude, DIRECTED[r].last_bin, DIRECTED[r].typed,
                     DIRECTED[r].want);
        end

        write_decay(8'd0);
        run_frames(30);
        write_decay(8'd255);
        run_frames(30);

        // No last flag for more than a full spectrum: the bin counter has to wrap by itself.
        for (int i = 0; i < METER_BINS + 8; i++) begin
            send_bin(pick_magnitude(), 1'b0, 1'b0, '0);
        end
        for (int i = 0; i < 3; i++) begin
            send_bin(pick_magnitude(), i == 2, 1'b0, '0);
        end

        write_decay(8'($urandom_range(1, 254)));
        run_frames(25);
        write_decay(8'($urandom_range(1, 254)));
        run_frames(25);

        s_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("spectral_flux_peak_hold_unit_tb OK");
        end else begin
            $display("spectral_flux_peak_hold_unit_tb NOT OK");
        end
        $finish;
    end

    // Result checking and receiver stalls share one process, so the hold-off sees the
    // result count of the same edge.
    always @(posedge aclk) begin : result_side
        meter_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bins.size() == 0) begin
                report_mismatch("result with no request pending", 16'(m_held_level), '0);
            end else begin
                want = expected_bins.pop_front();
                if (m_held_level !== want.held_level) begin
                    report_mismatch("held_level", 16'(m_held_level), 16'(want.held_level));
                end
                if (m_flux !== want.flux) begin
                    report_mismatch("flux", 16'(m_flux), 16'(want.flux));
                end
                if (m_bass_average !== want.bass_average) begin
                    report_mismatch("bass_average", 16'(m_bass_average),
                                    16'(want.bass_average));
                end
                if (m_frame_end !== want.frame_end) begin
                    report_mismatch("frame_end", 16'(m_frame_end), 16'(want.frame_end));
                end
            end
            results_seen++;
        end

        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            // One long hold-off so that the pipeline fills and pushes back on its input.
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(5, 60);
            end
            mode_left--;
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_HALF:   m_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:      m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("spectral_flux_peak_hold_unit_tb NOT OK");
        $finish;
    end

endmodule
